FILE: rtl/vtsp_pkg.sv
// Package for the view-to-screen vertex projection block.
// Holds the shared widths, register codes, configuration and sideband types.
// Used by every module of the block; depends on nothing.
package vtsp_pkg;

  localparam int unsigned DIV_W = 31;
  localparam int unsigned QUO_W = 41;
  localparam int unsigned NUM_W = DIV_W + QUO_W + 7;

  localparam logic MODE_ORTHO = 1'b0;
  localparam logic MODE_PERSP = 1'b1;

  localparam logic [63:0] FACTOR_RST    = 64'd1374389534720;
  localparam logic [31:0] FOCAL_RST     = 32'd20971520;
  localparam logic [31:0] ASPECT_RST    = 32'd65536;
  localparam logic [31:0] ORTHO_RST     = 32'd65536;
  localparam logic [31:0] CENTER_X_RST  = 32'd20971520;
  localparam logic [31:0] CENTER_Y_RST  = 32'd15728640;

  localparam logic [DIV_W-1:0] ORTHO_DIV     = DIV_W'(65536);
  localparam logic [31:0]      INV_SAT_DEPTH = 32'd16384;
  localparam logic [DIV_W-1:0] INV_REM0      = DIV_W'(32);
  localparam logic [QUO_W-1:0] INV_BITS0     = '0;
  localparam logic [QUO_W-1:0] OFFSET_CAP    = QUO_W'(64'd1099511627776);

  typedef enum logic [2:0] {
    REG_MODE     = 3'd0,
    REG_FOCAL    = 3'd1,
    REG_ASPECT   = 3'd2,
    REG_ORTHO    = 3'd3,
    REG_CENTER_X = 3'd4,
    REG_CENTER_Y = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic               mode;
    logic [63:0]        factor;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
  } cfg_t;

  typedef struct packed {
    logic mode;
    logic invalid;
    logic neg_x;
    logic neg_z;
    logic zero_x;
    logic zero_z;
    logic ovf_x;
    logic ovf_z;
    logic ovf_inv;
  } side_t;

  function automatic logic [31:0] sat32(input logic [42:0] v);
    logic [31:0] r;
    if ((v[42:31] == '0) || (v[42:31] == '1)) begin
      r = v[31:0];
    end else if (v[42]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7FFF_FFFF;
    end
    return r;
  endfunction

endpackage

FILE: rtl/vtsp_regs.sv
// Configuration register file with its APB-style write and read port.
// Also registers the combined scale factor used by the datapath.
// Depends on vtsp_pkg.
module vtsp_regs
  import vtsp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  logic        mode_q;
  logic [31:0] focal_q;
  logic [31:0] aspect_q;
  logic [31:0] ortho_q;
  logic [31:0] center_x_q;
  logic [31:0] center_y_q;
  logic [63:0] factor_q;
  logic [63:0] factor_d;
  logic        wr_en;
  reg_idx_e    idx;

  assign idx    = reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_PERSP;
      focal_q    <= FOCAL_RST;
      aspect_q   <= ASPECT_RST;
      ortho_q    <= ORTHO_RST;
      center_x_q <= CENTER_X_RST;
      center_y_q <= CENTER_Y_RST;
    end else if (wr_en) begin
      case (idx)
        REG_MODE:     mode_q     <= pwdata[0];
        REG_FOCAL:    focal_q    <= pwdata;
        REG_ASPECT:   aspect_q   <= pwdata;
        REG_ORTHO:    ortho_q    <= pwdata;
        REG_CENTER_X: center_x_q <= pwdata;
        REG_CENTER_Y: center_y_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MODE:     prdata = {31'b0, mode_q};
      REG_FOCAL:    prdata = focal_q;
      REG_ASPECT:   prdata = aspect_q;
      REG_ORTHO:    prdata = ortho_q;
      REG_CENTER_X: prdata = center_x_q;
      REG_CENTER_Y: prdata = center_y_q;
      default:      prdata = '0;
    endcase
  end

  assign factor_d = {32'b0, ((mode_q == MODE_PERSP) ? focal_q : ortho_q)} * {32'b0, aspect_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q <= FACTOR_RST;
    end else begin
      factor_q <= factor_d;
    end
  end

  assign cfg_o.mode     = mode_q;
  assign cfg_o.factor   = factor_q;
  assign cfg_o.center_x = center_x_q;
  assign cfg_o.center_y = center_y_q;

endmodule

FILE: rtl/vtsp_div.sv
// Pipelined restoring divider that settles one quotient bit per stage.
// The dividend arrives as a partial remainder below the divisor and its low bits.
// Depends on vtsp_pkg.
module vtsp_div
  import vtsp_pkg::*;
(
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [DIV_W-1:0] divisor_i,
  input  logic [DIV_W-1:0] rem_i,
  input  logic [QUO_W-1:0] bits_i,
  output logic [QUO_W-1:0] quot_o
);

  logic [DIV_W-1:0] div_q  [QUO_W];
  logic [DIV_W-1:0] rem_q  [QUO_W];
  logic [QUO_W-1:0] bits_q [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    logic [DIV_W-1:0] d_in;
    logic [DIV_W-1:0] r_in;
    logic [QUO_W-1:0] b_in;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic             ge;
    logic [DIV_W-1:0] rem_d;

    if (k == 0) begin : g_first
      assign d_in = divisor_i;
      assign r_in = rem_i;
      assign b_in = bits_i;
    end else begin : g_next
      assign d_in = div_q[k-1];
      assign r_in = rem_q[k-1];
      assign b_in = bits_q[k-1];
    end

    assign trial = {r_in, b_in[QUO_W-1]};
    assign diff  = trial - {1'b0, d_in};
    assign ge    = trial >= {1'b0, d_in};
    assign rem_d = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        div_q[k]  <= d_in;
        rem_q[k]  <= rem_d;
        bits_q[k] <= {b_in[QUO_W-2:0], ge};
      end
    end
  end

  assign quot_o = bits_q[QUO_W-1];

endmodule

FILE: rtl/vtsp_front.sv
// Front end of the projection pipeline: input register, magnitudes and
// partial products, the wide sum, and the divider overflow check. Depends on vtsp_pkg.
module vtsp_front
  import vtsp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [31:0]      view_x_i,
  input  logic [31:0]      view_depth_i,
  input  logic [31:0]      view_z_i,
  input  cfg_t             cfg_i,
  output logic             valid_o,
  output side_t            side_o,
  output logic [DIV_W-1:0] div_xz_o,
  output logic [DIV_W-1:0] div_inv_o,
  output logic [DIV_W-1:0] rem_x_o,
  output logic [QUO_W-1:0] bits_x_o,
  output logic [DIV_W-1:0] rem_z_o,
  output logic [QUO_W-1:0] bits_z_o
);

  logic             a_vld_q, b_vld_q, c_vld_q, d_vld_q;
  logic [31:0]      a_x_q, a_d_q, a_z_q;

  logic             neg_x, neg_z, invalid;
  logic [31:0]      mag_x, mag_z;
  logic [DIV_W-1:0] dxz, dinv;
  side_t            b_side_d;

  logic [63:0]      b_pxl_q, b_pxh_q, b_pzl_q, b_pzh_q;
  side_t            b_side_q;
  logic [DIV_W-1:0] b_dxz_q, b_dinv_q;

  logic [95:0]      sum_x, sum_z;
  logic [NUM_W-1:0] c_nx_q, c_nz_q;
  side_t            c_side_q;
  logic [DIV_W-1:0] c_dxz_q, c_dinv_q;

  side_t            d_side_d, d_side_q;
  logic [DIV_W-1:0] d_dxz_q, d_dinv_q;
  logic [DIV_W-1:0] d_rem_x_q, d_rem_z_q;
  logic [QUO_W-1:0] d_bits_x_q, d_bits_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
    end else if (en_i) begin
      a_vld_q <= valid_i;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_x_q <= view_x_i;
      a_d_q <= view_depth_i;
      a_z_q <= view_z_i;
    end
  end

  always_comb begin
    neg_x   = a_x_q[31];
    neg_z   = a_z_q[31];
    mag_x   = neg_x ? (~a_x_q + 32'd1) : a_x_q;
    mag_z   = neg_z ? (~a_z_q + 32'd1) : a_z_q;
    invalid = a_d_q[31] || (a_d_q == '0);
    dinv    = invalid ? DIV_W'(1) : a_d_q[DIV_W-1:0];
    dxz     = (cfg_i.mode == MODE_ORTHO) ? ORTHO_DIV : dinv;

    b_side_d         = '0;
    b_side_d.mode    = cfg_i.mode;
    b_side_d.invalid = invalid;
    b_side_d.neg_x   = neg_x;
    b_side_d.neg_z   = neg_z;
    b_side_d.zero_x  = (a_x_q == '0);
    b_side_d.zero_z  = (a_z_q == '0);
    b_side_d.ovf_inv = invalid || (a_d_q <= INV_SAT_DEPTH);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_pxl_q  <= {32'b0, mag_x} * {32'b0, cfg_i.factor[31:0]};
      b_pxh_q  <= {32'b0, mag_x} * {32'b0, cfg_i.factor[63:32]};
      b_pzl_q  <= {32'b0, mag_z} * {32'b0, cfg_i.factor[31:0]};
      b_pzh_q  <= {32'b0, mag_z} * {32'b0, cfg_i.factor[63:32]};
      b_side_q <= b_side_d;
      b_dxz_q  <= dxz;
      b_dinv_q <= dinv;
    end
  end

  assign sum_x = {b_pxh_q, 32'b0} + {32'b0, b_pxl_q};
  assign sum_z = {b_pzh_q, 32'b0} + {32'b0, b_pzl_q};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_nx_q   <= sum_x[NUM_W+15:16];
      c_nz_q   <= sum_z[NUM_W+15:16];
      c_side_q <= b_side_q;
      c_dxz_q  <= b_dxz_q;
      c_dinv_q <= b_dinv_q;
    end
  end

  always_comb begin
    d_side_d       = c_side_q;
    d_side_d.ovf_x = c_nx_q[NUM_W-1:QUO_W] >= {7'b0, c_dxz_q};
    d_side_d.ovf_z = c_nz_q[NUM_W-1:QUO_W] >= {7'b0, c_dxz_q};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_side_q   <= d_side_d;
      d_dxz_q    <= c_dxz_q;
      d_dinv_q   <= c_dinv_q;
      d_rem_x_q  <= c_nx_q[DIV_W+QUO_W-1:QUO_W];
      d_rem_z_q  <= c_nz_q[DIV_W+QUO_W-1:QUO_W];
      d_bits_x_q <= c_nx_q[QUO_W-1:0];
      d_bits_z_q <= c_nz_q[QUO_W-1:0];
    end
  end

  assign valid_o   = d_vld_q;
  assign side_o    = d_side_q;
  assign div_xz_o  = d_dxz_q;
  assign div_inv_o = d_dinv_q;
  assign rem_x_o   = d_rem_x_q;
  assign bits_x_o  = d_bits_x_q;
  assign rem_z_o   = d_rem_z_q;
  assign bits_z_o  = d_bits_z_q;

endmodule

FILE: rtl/view_to_screen_vertex_projection.sv
// Top level of the view-to-screen vertex projection block.
// Instantiates vtsp_regs, vtsp_front and three vtsp_div pipelines; uses vtsp_pkg.
//
// The block accepts one view-space vertex per clock while the output is not
// stalled and returns one projected vertex per vertex, in order, through four
// front stages, one stage per quotient bit of the 41-bit pipelined divider, and
// the output register. A stall on the output holds the whole pipeline in place.
// A configuration write reaches a vertex where that vertex samples it: the mode
// and the registered scale factor in the front stages, the centres at the output.
module view_to_screen_vertex_projection
  import vtsp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] view_x_i,
  input  logic signed [31:0] view_depth_i,
  input  logic signed [31:0] view_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] screen_x_o,
  output logic signed [31:0] screen_y_o,
  output logic [31:0]        inv_depth_o,
  output logic               depth_invalid_o
);

  cfg_t             cfg;
  logic             adv;
  logic             front_vld;
  side_t            front_side;
  logic [DIV_W-1:0] div_xz, div_inv, rem_x, rem_z;
  logic [QUO_W-1:0] bits_x, bits_z;
  logic [QUO_W-1:0] quot_x, quot_z, quot_inv;

  logic [QUO_W-1:0] pipe_vld_q;
  side_t            pipe_side_q [QUO_W];
  side_t            side;

  logic [QUO_W-1:0] mag_x, mag_z;
  logic [42:0]      off_x, off_y, sum_x, sum_y;
  logic [31:0]      sx_d, sy_d, inv_d;

  logic             out_vld_q;
  logic [31:0]      sx_q, sy_q, inv_q;
  logic             invalid_q;

  assign adv        = !out_vld_q || out_ready_i;
  assign in_ready_o = adv;

  vtsp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  vtsp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (adv),
    .valid_i      (in_valid_i),
    .view_x_i     (view_x_i),
    .view_depth_i (view_depth_i),
    .view_z_i     (view_z_i),
    .cfg_i        (cfg),
    .valid_o      (front_vld),
    .side_o       (front_side),
    .div_xz_o     (div_xz),
    .div_inv_o    (div_inv),
    .rem_x_o      (rem_x),
    .bits_x_o     (bits_x),
    .rem_z_o      (rem_z),
    .bits_z_o     (bits_z)
  );

  vtsp_div u_div_x (
    .clk_i     (clk_i),
    .en_i      (adv),
    .divisor_i (div_xz),
    .rem_i     (rem_x),
    .bits_i    (bits_x),
    .quot_o    (quot_x)
  );

  vtsp_div u_div_z (
    .clk_i     (clk_i),
    .en_i      (adv),
    .divisor_i (div_xz),
    .rem_i     (rem_z),
    .bits_i    (bits_z),
    .quot_o    (quot_z)
  );

  vtsp_div u_div_inv (
    .clk_i     (clk_i),
    .en_i      (adv),
    .divisor_i (div_inv),
    .rem_i     (INV_REM0),
    .bits_i    (INV_BITS0),
    .quot_o    (quot_inv)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_vld_q <= '0;
    end else if (adv) begin
      pipe_vld_q <= {pipe_vld_q[QUO_W-2:0], front_vld};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pipe_side_q[0] <= front_side;
      for (int k = 1; k < QUO_W; k++) begin
        pipe_side_q[k] <= pipe_side_q[k-1];
      end
    end
  end

  assign side = pipe_side_q[QUO_W-1];

  always_comb begin
    mag_x = (side.ovf_x || (quot_x > OFFSET_CAP)) ? OFFSET_CAP : quot_x;
    mag_z = (side.ovf_z || (quot_z > OFFSET_CAP)) ? OFFSET_CAP : quot_z;
    off_x = side.neg_x ? (43'd0 - {2'b0, mag_x}) : {2'b0, mag_x};
    off_y = side.neg_z ? {2'b0, mag_z} : (43'd0 - {2'b0, mag_z});
    sum_x = {{11{cfg.center_x[31]}}, cfg.center_x} + off_x;
    sum_y = {{11{cfg.center_y[31]}}, cfg.center_y} + off_y;

    if ((side.mode == MODE_PERSP) && side.invalid) begin
      sx_d = side.zero_x ? cfg.center_x : (side.neg_x ? 32'h8000_0000 : 32'h7FFF_FFFF);
      sy_d = side.zero_z ? cfg.center_y : (side.neg_z ? 32'h7FFF_FFFF : 32'h8000_0000);
    end else begin
      sx_d = sat32(sum_x);
      sy_d = sat32(sum_y);
    end

    inv_d = (side.ovf_inv || (quot_inv[QUO_W-1:32] != '0)) ? 32'hFFFF_FFFF : quot_inv[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= pipe_vld_q[QUO_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sx_q      <= sx_d;
      sy_q      <= sy_d;
      inv_q     <= inv_d;
      invalid_q <= side.invalid;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign screen_x_o      = sx_q;
  assign screen_y_o      = sy_q;
  assign inv_depth_o     = inv_q;
  assign depth_invalid_o = invalid_q;

`ifndef SYNTH
  a_invalid_inv_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && depth_invalid_o |-> inv_depth_o == 32'hFFFF_FFFF)
    else $error("Invalid depth did not saturate the inverse depth.");

  a_valid_inv_floor : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !depth_invalid_o |-> inv_depth_o >= 32'h0000_8000)
    else $error("Inverse depth of a positive depth fell below its floor.");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(pipe_vld_q) && $stable(out_vld_q))
    else $error("Pipeline valid bits moved during an output stall.");
`endif

endmodule

FILE: tb/view_to_screen_vertex_projection_tb.sv
// Self-checking testbench for view_to_screen_vertex_projection.
// Streams vertices through the block under several register settings and checks each
// projected vertex against a local predictor; depends on vtsp_pkg and the RTL only.
`timescale 1ns / 1ps

module view_to_screen_vertex_projection_tb;
  import vtsp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] depth;
    logic [31:0] z;
  } vertex_t;

  typedef struct packed {
    logic [31:0] sx;
    logic [31:0] sy;
    logic [31:0] inv;
    logic        invalid;
  } projected_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [31:0] view_x_i = '0;
  logic signed [31:0] view_depth_i = '0;
  logic signed [31:0] view_z_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] screen_x_o;
  logic signed [31:0] screen_y_o;
  logic [31:0]        inv_depth_o;
  logic               depth_invalid_o;

  logic        cfg_mode = MODE_PERSP;
  logic [31:0] cfg_focal = FOCAL_RST;
  logic [31:0] cfg_aspect = ASPECT_RST;
  logic [31:0] cfg_ortho = ORTHO_RST;
  logic [31:0] cfg_cx = CENTER_X_RST;
  logic [31:0] cfg_cy = CENTER_Y_RST;

  vertex_t     vertex_q[$];
  projected_t  projection_q[$];
  logic        in_taken = 1'b0;
  logic        out_taken = 1'b0;
  logic        hold_req = 1'b0;
  int unsigned hold_cnt = 0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  logic        send_burst = 1'b0;
  logic        recv_burst = 1'b0;
  int unsigned cycle_cnt = 0;
  int unsigned mismatch_cnt = 0;

  vertex_t directed_set[12] = '{
    '{32'h0000_0000, 32'h0001_0000, 32'h0000_0000},
    '{32'h000A_0000, 32'h000A_0000, 32'hFFFB_0000},
    '{32'h7FFF_FFFF, 32'h0000_0001, 32'h8000_0000},
    '{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
    '{32'h0005_0000, 32'h0000_0000, 32'hFFFD_0000},
    '{32'hFFFB_0000, 32'h8000_0000, 32'h0003_0000},
    '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000},
    '{32'h0000_0001, 32'h0000_4000, 32'hFFFF_FFFF},
    '{32'h0000_0000, 32'h0000_4001, 32'h0000_0000},
    '{32'hFFFF_FFFF, 32'h0000_3FFF, 32'h0000_0001},
    '{32'h1234_5678, 32'h0001_0000, 32'hEDCB_A988},
    '{32'hFFFF_0000, 32'h03E8_0000, 32'h0001_0000}
  };

  view_to_screen_vertex_projection dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .view_x_i       (view_x_i),
    .view_depth_i   (view_depth_i),
    .view_z_i       (view_z_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .screen_x_o     (screen_x_o),
    .screen_y_o     (screen_y_o),
    .inv_depth_o    (inv_depth_o),
    .depth_invalid_o(depth_invalid_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [31:0] saturate_q16(logic signed [63:0] v);
    if (v > $signed(64'h0000_0000_7FFF_FFFF)) begin
      return 32'h7FFF_FFFF;
    end else if (v < $signed(64'hFFFF_FFFF_8000_0000)) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // The magnitude is scaled and divided exactly, truncated once, capped, then signed.
  function automatic logic signed [63:0] scaled_offset(logic [31:0] coord, logic [63:0] factor,
                                                       logic [47:0] divisor);
    logic [32:0]  mag;
    logic [127:0] quo;
    logic [63:0]  q;
    mag = coord[31] ? (33'h1_0000_0000 - {1'b0, coord}) : {1'b0, coord};
    quo = ({95'd0, mag} * {64'd0, factor}) / {80'd0, divisor};
    q = (quo > 128'(OFFSET_CAP)) ? 64'(OFFSET_CAP) : quo[63:0];
    return coord[31] ? -$signed(q) : $signed(q);
  endfunction

  function automatic projected_t project_vertex(vertex_t v);
    projected_t  r;
    logic [63:0] quo;
    logic [63:0] factor;
    logic [47:0] divisor;
    r.invalid = ($signed(v.depth) <= 0);
    if (r.invalid) begin
      r.inv = 32'hFFFF_FFFF;
    end else begin
      quo = (64'd1 << 46) / {32'd0, v.depth};
      r.inv = (quo > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
    end
    if (cfg_mode == MODE_PERSP && r.invalid) begin
      r.sx = ($signed(v.x) > 0) ? 32'h7FFF_FFFF : ($signed(v.x) < 0) ? 32'h8000_0000 : cfg_cx;
      r.sy = ($signed(v.z) > 0) ? 32'h8000_0000 : ($signed(v.z) < 0) ? 32'h7FFF_FFFF : cfg_cy;
    end else begin
      if (cfg_mode == MODE_ORTHO) begin
        factor = {32'd0, cfg_ortho} * {32'd0, cfg_aspect};
        divisor = 48'd1 << 32;
      end else begin
        factor = {32'd0, cfg_focal} * {32'd0, cfg_aspect};
        divisor = {v.depth, 16'd0};
      end
      r.sx = saturate_q16($signed(cfg_cx) + scaled_offset(v.x, factor, divisor));
      r.sy = saturate_q16($signed(cfg_cy) - scaled_offset(v.z, factor, divisor));
    end
    return r;
  endfunction

  function automatic logic [31:0] rand_coord();
    logic [31:0] m;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0: m = 32'h7FFF_FFFF;
          1: m = 32'h8000_0000;
          2: m = 32'h0000_0000;
          default: m = 32'hFFFF_FFFF;
        endcase
      end
      1: m = $urandom();
      default: begin
        m = $urandom_range(0, 32'h07D0_0000);
        if ($urandom_range(0, 1) != 0) m = -m;
      end
    endcase
    return m;
  endfunction

  function automatic logic [31:0] rand_depth();
    logic [31:0] d;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 2))
          0: d = 32'h0000_0000;
          1: d = 32'h8000_0000;
          default: d = -$urandom_range(1, 32'h7FFF_FFFF);
        endcase
      end
      1: d = $urandom_range(1, 32'h0001_0000);
      2: d = $urandom_range(1, 32'h7FFF_FFFF);
      default: d = $urandom_range(32'h0001_0000, 32'h1388_0000);
    endcase
    return d;
  endfunction

  function automatic logic [31:0] rand_setting();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(32'h0001_0000, 32'h03E8_0000);
      2: return $urandom_range(0, 32'h0002_0000);
      default: return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0000_0000;
    endcase
  endfunction

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_MODE:     cfg_mode = value[0];
      REG_FOCAL:    cfg_focal = value;
      REG_ASPECT:   cfg_aspect = value;
      REG_ORTHO:    cfg_ortho = value;
      REG_CENTER_X: cfg_cx = value;
      REG_CENTER_Y: cfg_cy = value;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic load_setup(input logic mode, input logic [31:0] focal, input logic [31:0] aspect,
                            input logic [31:0] ortho, input logic [31:0] cx,
                            input logic [31:0] cy);
    write_reg(REG_MODE, ($urandom() & 32'hFFFF_FFFE) | {31'd0, mode});
    write_reg(REG_FOCAL, focal);
    write_reg(REG_ASPECT, aspect);
    write_reg(REG_ORTHO, ortho);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (vertex_q.size() != 0 || in_valid_i || projection_q.size() != 0);
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatch_cnt++;
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
  endtask

  always @(negedge clk_i) begin
    vertex_t nxt;
    if (rst_ni && !(in_valid_i && !in_taken)) begin
      if (send_gap != 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (vertex_q.size() != 0) begin
        nxt = vertex_q.pop_front();
        in_valid_i <= 1'b1;
        view_x_i <= nxt.x;
        view_depth_i <= nxt.depth;
        view_z_i <= nxt.z;
        if ($urandom_range(0, 19) == 0) send_burst = !send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, 9);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HOLD_CYCLES;
      end
      if (out_taken) begin
        if ($urandom_range(0, 19) == 0) recv_burst = !recv_burst;
        recv_gap = recv_burst ? 0 : $urandom_range(0, 9);
      end
      if (hold_cnt != 0) begin
        hold_cnt--;
        out_ready_i <= 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    projected_t want;
    if (rst_ni) begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
      in_taken <= in_valid_i && in_ready_o;
      out_taken <= out_valid_o && out_ready_i;
      if (in_valid_i && in_ready_o) begin
        projection_q.push_back(project_vertex('{view_x_i, view_depth_i, view_z_i}));
      end
      if (out_valid_o && out_ready_i) begin
        if (projection_q.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: unexpected transfer, expected none, actual %h %h %h %b", $time,
                   screen_x_o, screen_y_o, inv_depth_o, depth_invalid_o);
        end else begin
          want = projection_q.pop_front();
          if (screen_x_o !== want.sx) report_mismatch("screen_x", want.sx, screen_x_o);
          if (screen_y_o !== want.sy) report_mismatch("screen_y", want.sy, screen_y_o);
          if (inv_depth_o !== want.inv) report_mismatch("inv_depth", want.inv, inv_depth_o);
          if (depth_invalid_o !== want.invalid) begin
            report_mismatch("depth_invalid", {31'd0, want.invalid}, {31'd0, depth_invalid_o});
          end
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_set[i]) vertex_q.push_back(directed_set[i]);
    wait_drained();
    write_reg(REG_MODE, {31'd0, MODE_ORTHO});
    foreach (directed_set[i]) vertex_q.push_back(directed_set[i]);

    for (int p = 0; p < 8; p++) begin
      wait_drained();
      case (p)
        0: load_setup(MODE_PERSP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      32'h7FFF_FFFF, 32'h8000_0000);
        1: load_setup(MODE_ORTHO, 32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF);
        2: load_setup(MODE_ORTHO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      32'h7FFF_FFFF, 32'h8000_0000);
        3: load_setup(MODE_PERSP, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        default: load_setup(($urandom_range(0, 1) != 0) ? MODE_PERSP : MODE_ORTHO,
                            rand_setting(), rand_setting(), rand_setting(),
                            rand_setting(), rand_setting());
      endcase
      if (p == 4) hold_req = 1'b1;
      repeat (110) vertex_q.push_back('{rand_coord(), rand_depth(), rand_coord()});
    end

    wait_drained();
    repeat (60) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/vtsp_pkg.sv
rtl/vtsp_regs.sv
rtl/vtsp_div.sv
rtl/vtsp_front.sv
rtl/view_to_screen_vertex_projection.sv
tb/view_to_screen_vertex_projection_tb.sv
